[rtl/ehist_pkg.sv]
// ----------------------------------------------------------------------------
// ehist_pkg: shared definitions for the binned event histogram
// Widths, defaults and the ranker command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package ehist_pkg;

   localparam int NUM_BINS_DEF  = 24;   // hour bins
   localparam int TOP_COUNT_DEF = 3;    // ranks kept
   localparam int SHOWN_RANKS   = 3;    // ranks on the result port
   localparam int BIN_W         = 5;    // bin field width
   localparam int CNT_W         = 8;    // counter width

   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd254;

   // command from the sequencer to the ranker
   typedef struct packed {
      logic             clear;   // start a new ranking
      logic             load;    // offer one (count, bin) pair
      logic [CNT_W-1:0] cnt;
      logic [BIN_W-1:0] bin;
   } rank_cmd_type;

endpackage

`default_nettype wire

[rtl/binned_event_histogram_top3_core.sv]
// ----------------------------------------------------------------------------
// binned_event_histogram_top3_core: hour-bin event histogram with top-3 ranks
// Saturating per-bin counters in a small memory, ranked at period end.
// ----------------------------------------------------------------------------
// One item is handled at a time. For a record item (req_type 0) the counter
// is read from the memory, then bumped (saturating at 254) and written back
// while the result is loaded. For an end-of-period item (req_type 1) the
// memory read port sweeps one bin per cycle into the ranking list, then all
// counters are dropped at once by clearing their valid bits. Every transfer
// in gives exactly one transfer out carrying the addressed bin's new count
// (0 for a bin out of range or after a period end) and the current top three
// bins, where NUM_BINS means none. The result register lets a new item be
// taken while the previous result still waits; a full result register with
// rsp_ready low stalls the item in its final cycle. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_event_histogram_top3_core
   import ehist_pkg::*;
#(
   parameter int NUM_BINS  = NUM_BINS_DEF,
   parameter int TOP_COUNT = TOP_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_type,
   input  wire logic [BIN_W-1:0] req_bin,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [CNT_W-1:0] rsp_bin_count,
   output logic      [BIN_W-1:0] rsp_top_first,
   output logic      [BIN_W-1:0] rsp_top_second,
   output logic      [BIN_W-1:0] rsp_top_third
);

   localparam int AW = $clog2(NUM_BINS);
   localparam logic [AW-1:0]    LAST_IDX = AW'(NUM_BINS - 1);
   localparam logic [BIN_W-1:0] NONE_BIN = BIN_W'(NUM_BINS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // waiting for a request transfer
      S_RD   = 4'b0010,   // record: counter read data is back
      S_SCAN = 4'b0100,   // period end: one bin per cycle into the ranker
      S_DONE = 4'b1000    // period end: clear counters, report ranking
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] addr_ff, addr_in;   // bin of the record in flight
   logic          rng_ff, rng_in;     // bin is inside the histogram
   logic [AW-1:0] idx_ff, idx_in;     // scan position

   // memory and ranker hookup
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [CNT_W-1:0] mem_rd_data;
   logic             mem_wr_en;
   logic [CNT_W-1:0] mem_wr_data;
   logic             mem_clear;
   rank_cmd_type     rank_cmd;
   logic [TOP_COUNT-1:0][BIN_W-1:0] top_bins;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] cnt_out_ff;
   logic [BIN_W-1:0] top0_ff, top1_ff, top2_ff;
   logic             out_load;
   logic [CNT_W-1:0] out_cnt;
   logic             out_free;
   logic [BIN_W-1:0] shown [SHOWN_RANKS];

   ehist_cnt_mem #(
      .NUM_BINS (NUM_BINS)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_data   (mem_rd_data),
      .wr_en     (mem_wr_en),
      .wr_addr   (addr_ff),
      .wr_data   (mem_wr_data),
      .clear_all (mem_clear)
   );

   ehist_rank #(
      .NUM_BINS  (NUM_BINS),
      .TOP_COUNT (TOP_COUNT)
   ) u_rank (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rank_cmd),
      .top_bins (top_bins)
   );

   // ranks past TOP_COUNT read none
   for (genvar k = 0; k < SHOWN_RANKS; k++) begin : g_shown
      if (k < TOP_COUNT) begin : g_kept
         assign shown[k] = top_bins[k];
      end else begin : g_none
         assign shown[k] = NONE_BIN;
      end
   end

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // saturating bump of the counter just read
   assign mem_wr_data = (mem_rd_data < COUNT_MAX) ? mem_rd_data + CNT_W'(1) : mem_rd_data;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      rng_in      = rng_ff;
      idx_in      = idx_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff;
      mem_wr_en   = 1'b0;
      mem_clear   = 1'b0;
      rank_cmd    = '0;
      out_load    = 1'b0;
      out_cnt     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rng_in  = req_bin < NONE_BIN;
               addr_in = req_bin[AW-1:0];
               if (req_type) begin
                  // period end: start the sweep at bin 0
                  mem_rd_en      = 1'b1;
                  mem_rd_addr    = '0;
                  idx_in         = '0;
                  rank_cmd.clear = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  mem_rd_en   = req_bin < NONE_BIN;
                  mem_rd_addr = req_bin[AW-1:0];
                  state_in    = S_RD;
               end
            end
         end
         S_RD: begin
            // on stall nothing is written yet: read data is held until the write
            if (out_free) begin
               mem_wr_en = rng_ff;
               out_load  = 1'b1;
               out_cnt   = rng_ff ? mem_wr_data : '0;
               state_in  = S_IDLE;
            end
         end
         S_SCAN: begin
            rank_cmd.load = 1'b1;
            rank_cmd.cnt  = mem_rd_data;
            rank_cmd.bin  = BIN_W'(idx_ff);
            if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + AW'(1);
               idx_in      = idx_ff + AW'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               mem_clear = 1'b1;
               out_load  = 1'b1;
               out_cnt   = '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rng_ff  <= rng_in;
      idx_ff  <= idx_in;
      if (out_load) begin
         cnt_out_ff <= out_cnt;
         top0_ff    <= shown[0];
         top1_ff    <= shown[1];
         top2_ff    <= shown[2];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_count  = cnt_out_ff;
   assign rsp_top_first  = top0_ff;
   assign rsp_top_second = top1_ff;
   assign rsp_top_third  = top2_ff;

endmodule

`default_nettype wire

[rtl/ehist_cnt_mem.sv]
// ----------------------------------------------------------------------------
// ehist_cnt_mem: bin counter store
// One write port, one read port, registered read data. Per-entry valid
// bits make a cleared entry read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ehist_cnt_mem
   import ehist_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   localparam int AW      = $clog2(NUM_BINS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [CNT_W-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [CNT_W-1:0] wr_data,
   input  wire logic             clear_all
);

   logic [CNT_W-1:0]    mem [NUM_BINS];
   logic [NUM_BINS-1:0] vld_ff;
   logic [NUM_BINS-1:0] vld_in;
   logic [CNT_W-1:0]    rd_data_ff;

   always_comb begin
      vld_in = vld_ff;
      if (clear_all) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ehist_rank.sv]
// ----------------------------------------------------------------------------
// ehist_rank: top-k ranking list
// Keeps the TOP_COUNT highest (count, bin) pairs, sorted, by insertion.
// Pairs arrive in ascending bin order; ties keep the earlier bin ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module ehist_rank
   import ehist_pkg::*;
#(
   parameter int NUM_BINS  = NUM_BINS_DEF,
   parameter int TOP_COUNT = TOP_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rank_cmd_type                      cmd,
   output logic [TOP_COUNT-1:0][BIN_W-1:0]        top_bins
);

   localparam logic [BIN_W-1:0] NONE_BIN = BIN_W'(NUM_BINS);

   logic [CNT_W-1:0] cnt_ff [TOP_COUNT];
   logic [CNT_W-1:0] cnt_in [TOP_COUNT];
   logic [BIN_W-1:0] bin_ff [TOP_COUNT];
   logic [BIN_W-1:0] bin_in [TOP_COUNT];
   logic [TOP_COUNT-1:0] gt;

   // gt is a suffix mask since the list is sorted descending
   for (genvar j = 0; j < TOP_COUNT; j++) begin : g_slot
      assign gt[j] = cmd.cnt > cnt_ff[j];

      if (j == 0) begin : g_head
         always_comb begin
            cnt_in[j] = cnt_ff[j];
            bin_in[j] = bin_ff[j];
            if (cmd.clear) begin
               cnt_in[j] = '0;
               bin_in[j] = NONE_BIN;
            end else if (cmd.load && gt[j]) begin
               cnt_in[j] = cmd.cnt;
               bin_in[j] = cmd.bin;
            end
         end
      end else begin : g_tail
         always_comb begin
            cnt_in[j] = cnt_ff[j];
            bin_in[j] = bin_ff[j];
            if (cmd.clear) begin
               cnt_in[j] = '0;
               bin_in[j] = NONE_BIN;
            end else if (cmd.load && gt[j]) begin
               if (gt[j-1]) begin
                  cnt_in[j] = cnt_ff[j-1];
                  bin_in[j] = bin_ff[j-1];
               end else begin
                  cnt_in[j] = cmd.cnt;
                  bin_in[j] = cmd.bin;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[j] <= '0;
            bin_ff[j] <= NONE_BIN;
         end else begin
            cnt_ff[j] <= cnt_in[j];
            bin_ff[j] <= bin_in[j];
         end
      end

      assign top_bins[j] = bin_ff[j];
   end

endmodule

`default_nettype wire

[test/binned_event_histogram_top3_core_tb.sv]
// ----------------------------------------------------------------------------
// binned_event_histogram_top3_core_tb: self-checking bench for the histogram
// Drives record and period-end transfers with random handshake gaps, predicts
// every result from a local copy of the counters and the ranking, and checks
// each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binned_event_histogram_top3_core_tb;
   import ehist_pkg::*;

   // request kinds carried on req_type
   typedef enum logic {
      REQ_RECORD     = 1'b0,
      REQ_PERIOD_END = 1'b1
   } req_kind_type;

   // one result transfer, as seen on the rsp_ ports
   typedef struct {
      logic [CNT_W-1:0] bin_count;
      logic [BIN_W-1:0] first;
      logic [BIN_W-1:0] second;
      logic [BIN_W-1:0] third;
   } hist_result_type;

   localparam logic [BIN_W-1:0] NO_BIN = BIN_W'(NUM_BINS_DEF);

   // ---------------------------------------------------------------------------
   // DUT signals; every input holds a known value from time zero
   // ---------------------------------------------------------------------------
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_type  = 1'b0;
   logic [BIN_W-1:0] req_bin   = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [CNT_W-1:0] rsp_bin_count;
   logic [BIN_W-1:0] rsp_top_first;
   logic [BIN_W-1:0] rsp_top_second;
   logic [BIN_W-1:0] rsp_top_third;

   binned_event_histogram_top3_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_bin        (req_bin),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_count  (rsp_bin_count),
      .rsp_top_first  (rsp_top_first),
      .rsp_top_second (rsp_top_second),
      .rsp_top_third  (rsp_top_third)
   );

   initial forever #1 clock = ~clock;

   // Watchdog, set far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: per-bin tallies and the ranking from the last period end
   // ---------------------------------------------------------------------------
   logic [CNT_W-1:0] bin_tally [NUM_BINS_DEF];
   logic [BIN_W-1:0] top_bins  [TOP_COUNT_DEF];
   hist_result_type  results_due [$];

   int send_idle_pct = 0;   // chance in 100 that the sender idles a cycle
   int recv_idle_pct = 0;   // chance in 100 that rsp_ready drops
   int fail_count    = 0;

   // run statistics for the closing summary
   int n_records      = 0;
   int n_period_ends  = 0;
   int n_out_of_range = 0;
   int n_saturated    = 0;
   int n_checked      = 0;

   initial begin
      for (int i = 0; i < NUM_BINS_DEF; i++) bin_tally[i] = '0;
      for (int r = 0; r < TOP_COUNT_DEF; r++) top_bins[r] = NO_BIN;
   end

   // Applies one accepted transfer to the local state and returns the result
   // the block must produce for it.
   function automatic hist_result_type histogram_step(req_kind_type kind,
                                                      logic [BIN_W-1:0] bin);
      logic [CNT_W-1:0] scan [NUM_BINS_DEF];
      logic [BIN_W-1:0] best_bin;
      logic [CNT_W-1:0] best_cnt;
      logic             in_range;
      hist_result_type  res;
      in_range = (bin < NUM_BINS_DEF);
      if (!in_range) n_out_of_range++;
      if (kind == REQ_RECORD) begin
         n_records++;
         if (in_range) begin
            if (bin_tally[bin] < COUNT_MAX) bin_tally[bin] = bin_tally[bin] + 1'b1;
            else n_saturated++;
         end
      end else begin
         n_period_ends++;
         // Rank from the pre-clear counts: strictly greater wins, so the lower
         // bin keeps a tie and an all-zero scan leaves the rank at none.
         for (int i = 0; i < NUM_BINS_DEF; i++) scan[i] = bin_tally[i];
         for (int r = 0; r < TOP_COUNT_DEF; r++) begin
            best_bin = NO_BIN;
            best_cnt = '0;
            for (int i = 0; i < NUM_BINS_DEF; i++) begin
               if (scan[i] > best_cnt) begin
                  best_cnt = scan[i];
                  best_bin = BIN_W'(i);
               end
            end
            top_bins[r] = best_bin;
            if (best_bin != NO_BIN) scan[best_bin] = '0;
         end
         for (int i = 0; i < NUM_BINS_DEF; i++) bin_tally[i] = '0;
      end
      res.bin_count = in_range ? bin_tally[bin] : '0;
      res.first     = top_bins[0];
      res.second    = (TOP_COUNT_DEF > 1) ? top_bins[1] : NO_BIN;
      res.third     = (TOP_COUNT_DEF > 2) ? top_bins[2] : NO_BIN;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure plus the in-order check
   // ---------------------------------------------------------------------------
   task automatic check_result();
      hist_result_type due;
      if (results_due.size() == 0) begin
         $error("result transfer with nothing expected: count %0d tops %0d %0d %0d",
                rsp_bin_count, rsp_top_first, rsp_top_second, rsp_top_third);
         fail_count++;
         return;
      end
      due = results_due.pop_front();
      n_checked++;
      if (rsp_bin_count !== due.bin_count) begin
         $error("bin_count: expected %0d, got %0d", due.bin_count, rsp_bin_count);
         fail_count++;
      end
      if (rsp_top_first !== due.first) begin
         $error("top_first: expected %0d, got %0d", due.first, rsp_top_first);
         fail_count++;
      end
      if (rsp_top_second !== due.second) begin
         $error("top_second: expected %0d, got %0d", due.second, rsp_top_second);
         fail_count++;
      end
      if (rsp_top_third !== due.third) begin
         $error("top_third: expected %0d, got %0d", due.third, rsp_top_third);
         fail_count++;
      end
   endtask

   // Values read here are the ones present at the edge, since the DUT and the
   // bench only update through nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   // Offers one transfer and returns at the edge that accepts it. valid stays
   // high after acceptance so back-to-back transfers need no extra edge.
   task automatic send_event(req_kind_type kind, logic [BIN_W-1:0] bin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_bin   <= bin;
      do @(posedge clock); while (!req_ready);
      results_due.push_back(histogram_step(kind, bin));
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // Fresh block: empty ranking, out-of-range bins read zero and change nothing.
   task automatic test_empty_and_out_of_range();
      send_event(REQ_PERIOD_END, 5'd0);
      send_event(REQ_RECORD, 5'd31);
      send_event(REQ_RECORD, 5'd24);
      send_event(REQ_RECORD, 5'd0);
      send_event(REQ_PERIOD_END, 5'd30);   // ranks bin 0 alone
      send_event(REQ_PERIOD_END, 5'd23);   // nothing counted: all none
   endtask

   // Descending order, ties to the lower bin, partial ranking with none.
   task automatic test_rank_order_and_ties();
      send_event(REQ_RECORD, 5'd23);
      send_event(REQ_RECORD, 5'd5);
      send_event(REQ_RECORD, 5'd12);
      send_event(REQ_RECORD, 5'd23);
      send_event(REQ_RECORD, 5'd7);
      send_event(REQ_RECORD, 5'd5);
      send_event(REQ_RECORD, 5'd0);
      send_event(REQ_RECORD, 5'd12);
      send_event(REQ_RECORD, 5'd23);
      send_event(REQ_RECORD, 5'd7);
      send_event(REQ_RECORD, 5'd5);
      send_event(REQ_PERIOD_END, 5'd23);   // 5 before 23, then 7 before 12
      send_event(REQ_RECORD, 5'd3);
      send_event(REQ_RECORD, 5'd16);
      send_event(REQ_PERIOD_END, 5'd16);   // two ranked, third reads none
   endtask

   // Drive one bin past the saturation point, then rank it.
   task automatic test_saturation();
      logic [BIN_W-1:0] hot;
      hot = BIN_W'($urandom_range(NUM_BINS_DEF - 1));
      repeat (COUNT_MAX + 3) send_event(REQ_RECORD, hot);
      send_event(REQ_RECORD, BIN_W'((hot + 1) % NUM_BINS_DEF));
      send_event(REQ_PERIOD_END, hot);
   endtask

   // Mostly records aimed at a few hot bins (so ties and reorderings are
   // common), some spread records, some out-of-range bins, and a period end
   // every twenty transfers or so.
   task automatic test_random_traffic(int unsigned n_items);
      int unsigned hot [4];
      int unsigned pick;
      for (int j = 0; j < 4; j++) hot[j] = $urandom_range(NUM_BINS_DEF - 1);
      for (int unsigned k = 0; k < n_items; k++) begin
         if (k == n_items / 2) wait_for_results();
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_event(REQ_PERIOD_END, BIN_W'($urandom_range(31)));
            for (int j = 0; j < 4; j++) hot[j] = $urandom_range(NUM_BINS_DEF - 1);
         end else if (pick < 13) begin
            send_event(REQ_RECORD, BIN_W'($urandom_range(31, NUM_BINS_DEF)));
         end else if (pick < 65) begin
            send_event(REQ_RECORD, BIN_W'(hot[$urandom_range(3)]));
         end else begin
            send_event(REQ_RECORD, BIN_W'($urandom_range(NUM_BINS_DEF - 1)));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed checks, then three random phases with the
   // idling swapped between the two sides and finally switched off.
   // ---------------------------------------------------------------------------
   initial begin
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 46;
      test_empty_and_out_of_range();
      test_rank_order_and_ties();
      test_saturation();
      test_random_traffic(175);

      send_idle_pct = 46;
      recv_idle_pct = 8;
      test_random_traffic(175);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(175);

      // drain, then keep watching for stray results
      req_valid <= 1'b0;
      guard = 0;
      while (results_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (NUM_BINS_DEF + 8) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d expected results never arrived", results_due.size());
         fail_count++;
      end

      $display("Sent %0d records and %0d period ends (%0d out-of-range bins, %0d saturated).",
               n_records, n_period_ends, n_out_of_range, n_saturated);
      $display("Checked %0d results across three idling mixes; %0d mismatches.",
               n_checked, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[binned_event_histogram_top3_core.f]
rtl/ehist_pkg.sv
rtl/ehist_cnt_mem.sv
rtl/ehist_rank.sv
rtl/binned_event_histogram_top3_core.sv
test/binned_event_histogram_top3_core_tb.sv
